// ----- src/ss_pkg.sv -----
// shared types and codes for the searchable stack
`default_nettype none

package ss_pkg;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic        hit;
        logic [31:0] top_value;
        logic [4:0]  fill_level;
        logic [1:0]  status;
    } ss_res_t;

endpackage

`default_nettype wire

// ----- src/ss_in_if.sv -----
// request channel interface: opcode and value
`default_nettype none

interface ss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ----- src/ss_out_if.sv -----
// response channel interface: search hit, top, fill level and status
`default_nettype none

interface ss_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] top_value;
    logic [4:0]  fill_level;
    logic [1:0]  status;

    modport source (output valid, output hit, output top_value, output fill_level,
                    output status, input ready);
    modport sink (input valid, input hit, input top_value, input fill_level,
                  input status, output ready);
endinterface

`default_nettype wire

// ----- src/ss_mem.sv -----
// entry storage: one write port, one read port with registered read data
`default_nettype none

module ss_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 4
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]         raddr,
    output logic      [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] ram [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= ram[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/ss_ctrl.sv -----
// stack sequencer: fill count, cached top, pop refill and serial search
`default_nettype none

module ss_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 4,
    parameter int CW         = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ss_in_if.sink                      req,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output ss_pkg::ss_res_t            res,
    output logic                       mem_we,
    output logic      [AW-1:0]         mem_waddr,
    output logic      [DATA_WIDTH-1:0] mem_wdata,
    output logic      [AW-1:0]         mem_raddr,
    input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POPRD = 2'd1;
    localparam logic [1:0] S_SRCH  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] top_reg, top_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]         idx_reg, idx_next;
    ss_pkg::ss_res_t       res_reg, res_next;

    logic [DATA_WIDTH-1:0] val;
    logic                  full;
    logic                  empty;
    logic                  acc;
    logic [CW-1:0]         count_inc;
    logic [CW-1:0]         count_dec;
    logic [CW-1:0]         count_dec2;
    logic [CW-1:0]         idx_inc;

    assign val        = DATA_WIDTH'(req.value);
    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign count_inc  = count_reg + CW'(1);
    assign count_dec  = count_reg - CW'(1);
    assign count_dec2 = count_reg - CW'(2);
    assign idx_inc    = CW'(idx_reg) + CW'(1);
    assign req.ready  = (state_reg == S_IDLE) && res_ready;
    assign acc        = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        top_next   = top_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[AW-1:0];
        mem_wdata  = val;
        mem_raddr  = '0;
        res_valid  = 1'b0;
        res.hit        = 1'b0;
        res.top_value  = 32'(top_reg);
        res.fill_level = 5'(count_reg);
        res.status     = ss_pkg::ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (req.opcode)
                        ss_pkg::OP_PUSH:
                        begin
                            res_valid = 1'b1;
                            if (full)
                            begin
                                res.status = ss_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                count_next     = count_inc;
                                top_next       = val;
                                res.top_value  = 32'(val);
                                res.fill_level = 5'(count_inc);
                            end
                        end
                        ss_pkg::OP_POP:
                        begin
                            if (empty)
                            begin
                                res_valid  = 1'b1;
                                res.status = ss_pkg::ST_EMPTY;
                            end
                            else if (count_dec == '0)
                            begin
                                res_valid      = 1'b1;
                                count_next     = '0;
                                top_next       = '0;
                                res.top_value  = '0;
                                res.fill_level = '0;
                            end
                            else
                            begin
                                count_next = count_dec;
                                mem_raddr  = count_dec2[AW-1:0];
                                state_next = S_POPRD;
                            end
                        end
                        ss_pkg::OP_SEARCH:
                        begin
                            if (empty)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                key_next   = val;
                                idx_next   = '0;
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_POPRD:
            begin
                top_next            = mem_rdata;
                res_next.hit        = 1'b0;
                res_next.top_value  = 32'(mem_rdata);
                res_next.fill_level = 5'(count_reg);
                res_next.status     = ss_pkg::ST_OK;
                state_next          = S_RESP;
            end
            S_SRCH:
            begin
                res_next.top_value  = 32'(top_reg);
                res_next.fill_level = 5'(count_reg);
                res_next.status     = ss_pkg::ST_OK;
                res_next.hit        = 1'b0;
                if (mem_rdata == key_reg)
                begin
                    res_next.hit = 1'b1;
                    state_next   = S_RESP;
                end
                else if (idx_inc == count_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next  = idx_inc[AW-1:0];
                    mem_raddr = idx_inc[AW-1:0];
                end
            end
            S_RESP:
            begin
                res_valid = 1'b1;
                res       = res_reg;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (count_reg != '0))
        else $error("search running on empty stack");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (req.opcode == ss_pkg::OP_PUSH) && !full)
        |=> (count_reg == $past(count_inc)))
        else $error("push did not grow the stack");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (req.opcode == ss_pkg::OP_POP) && !empty)
        |=> (count_reg == $past(count_dec)))
        else $error("pop did not shrink the stack");

    a_top_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (top_reg == '0))
        else $error("top not zero on empty stack");
`endif

endmodule

`default_nettype wire

// ----- src/searchable_stack.sv -----
// top level of the searchable stack with the response output register
`default_nettype none

// LIFO stack of up to DEPTH entries held in a RAM with one registered read
// port, with a membership search. a push, a refused push or pop, a pop that
// empties the stack, a search of an empty stack and the unused opcode are
// answered in the cycle they are accepted. a pop that leaves entries goes
// through accept with the read of the new top, capture of the read data,
// then hand-off of the response. a search is issued, then examines one
// entry per cycle, bottom first, stopping at the first match or after the
// last entry, then hands off the response. the search rate is set by the
// single RAM read port. every response word passes through one output
// register; a new request is taken only when that register is empty or
// drained in the same cycle, so a waiting response stalls the input.
module searchable_stack #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ss_in_if.sink     req,
    ss_out_if.source  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                  res_valid;
    logic                  res_ready;
    ss_pkg::ss_res_t       res;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic                  out_valid_reg;
    ss_pkg::ss_res_t       out_data_reg;

    ss_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ss_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_data_reg.hit;
    assign rsp.top_value  = out_data_reg.top_value;
    assign rsp.fill_level = out_data_reg.fill_level;
    assign rsp.status     = out_data_reg.status;

endmodule

`default_nettype wire

// ----- tb/sv/searchable_stack_tb.sv -----
// testbench for searchable_stack: directed table, then random words vs a stack predictor
`default_nettype none

module searchable_stack_tb;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int STACK_DEPTH  = 16;
    localparam int RANDOM_WORDS = 750;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 5000;

    typedef struct packed {
        logic [1:0]      op;
        logic [31:0]     val;
        logic [4:0]      reps;
        logic            typed;
        ss_pkg::ss_res_t res;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ss_in_if  req_if ();
    ss_out_if rsp_if ();

    searchable_stack i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [31:0]     held_words [STACK_DEPTH];
    int              held;
    ss_pkg::ss_res_t pending_rsp [$];

    int n_push, n_pop, n_search, n_hit, n_full, n_empty, n_nop, peak_fill;
    int mismatches, rsp_seen, quiet;
    logic hold_req, hold_done;

    // typed rows carry their response; others go through the predictor
    dir_row_t dir_rows [12] = '{
        '{ss_pkg::OP_POP,    32'h0000_0000, 5'd1,  1'b1,
          '{1'b0, 32'h0000_0000, 5'd0,  ss_pkg::ST_EMPTY}},
        '{ss_pkg::OP_SEARCH, 32'h0000_0000, 5'd1,  1'b1,
          '{1'b0, 32'h0000_0000, 5'd0,  ss_pkg::ST_OK}},
        '{OP_NOP,            32'hFFFF_FFFF, 5'd1,  1'b1,
          '{1'b0, 32'h0000_0000, 5'd0,  ss_pkg::ST_OK}},
        '{ss_pkg::OP_PUSH,   32'hFFFF_FFFF, 5'd1,  1'b1,
          '{1'b0, 32'hFFFF_FFFF, 5'd1,  ss_pkg::ST_OK}},
        '{ss_pkg::OP_SEARCH, 32'hFFFF_FFFF, 5'd1,  1'b1,
          '{1'b1, 32'hFFFF_FFFF, 5'd1,  ss_pkg::ST_OK}},
        '{ss_pkg::OP_SEARCH, 32'h0000_0000, 5'd1,  1'b1,
          '{1'b0, 32'hFFFF_FFFF, 5'd1,  ss_pkg::ST_OK}},
        '{OP_NOP,            32'h0000_0000, 5'd1,  1'b1,
          '{1'b0, 32'hFFFF_FFFF, 5'd1,  ss_pkg::ST_OK}},
        '{ss_pkg::OP_POP,    32'h1234_5678, 5'd1,  1'b1,
          '{1'b0, 32'h0000_0000, 5'd0,  ss_pkg::ST_OK}},
        '{ss_pkg::OP_PUSH,   32'h0000_0000, 5'd16, 1'b0,
          '{1'b0, 32'h0000_0000, 5'd0,  ss_pkg::ST_OK}},
        '{ss_pkg::OP_PUSH,   32'h8000_0000, 5'd1,  1'b1,
          '{1'b0, 32'h0000_000F, 5'd16, ss_pkg::ST_FULL}},
        '{ss_pkg::OP_SEARCH, 32'h0000_0000, 5'd1,  1'b1,
          '{1'b1, 32'h0000_000F, 5'd16, ss_pkg::ST_OK}},
        '{ss_pkg::OP_SEARCH, 32'h7FFF_FFFF, 5'd1,  1'b1,
          '{1'b0, 32'h0000_000F, 5'd16, ss_pkg::ST_OK}}
    };

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic ss_pkg::ss_res_t stack_apply(input logic [1:0] op,
                                                    input logic [31:0] v);
        ss_pkg::ss_res_t r;
        r = '0;
        r.status = ss_pkg::ST_OK;
        case (op)
            ss_pkg::OP_PUSH:
            begin
                n_push++;
                if (held == STACK_DEPTH)
                begin
                    r.status = ss_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    held_words[held] = v;
                    held++;
                end
            end
            ss_pkg::OP_POP:
            begin
                n_pop++;
                if (held == 0)
                begin
                    r.status = ss_pkg::ST_EMPTY;
                    n_empty++;
                end
                else
                    held--;
            end
            ss_pkg::OP_SEARCH:
            begin
                n_search++;
                for (int i = 0; i < held; i++)
                    if (held_words[i] == v)
                        r.hit = 1'b1;
                if (r.hit)
                    n_hit++;
            end
            default: n_nop++;
        endcase
        r.top_value  = (held == 0) ? 32'h0 : held_words[held - 1];
        r.fill_level = 5'(held);
        if (held > peak_fill)
            peak_fill = held;
        return r;
    endfunction

    function automatic logic [1:0] pick_op(input int lean);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return OP_NOP;
        case (lean)
            0: return (r < 60) ? ss_pkg::OP_PUSH :
                      (r < 75) ? ss_pkg::OP_POP : ss_pkg::OP_SEARCH;
            1: return (r < 20) ? ss_pkg::OP_PUSH :
                      (r < 70) ? ss_pkg::OP_POP : ss_pkg::OP_SEARCH;
            default: return (r < 37) ? ss_pkg::OP_PUSH :
                            (r < 67) ? ss_pkg::OP_POP : ss_pkg::OP_SEARCH;
        endcase
    endfunction

    function automatic logic [31:0] pick_value(input logic [1:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (op == ss_pkg::OP_SEARCH && held > 0 && r < 50)
            return held_words[$urandom_range(0, held - 1)];
        r = $urandom_range(0, 99);
        if (r < 35)
            return 32'($urandom_range(0, 7));
        if (r < 45)
            return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        return $urandom;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [31:0] v,
                             input logic typed, input ss_pkg::ss_res_t typed_res);
        ss_pkg::ss_res_t predicted;
        @(negedge clk);
        req_if.opcode = op;
        req_if.value  = v;
        req_if.valid  = 1'b1;
        do
            @(posedge clk);
        while (!req_if.ready);
        predicted = stack_apply(op, v);
        pending_rsp.insert(pending_rsp.size(), typed ? typed_res : predicted);
    endtask

    task automatic rest(input int cycles);
        @(negedge clk);
        req_if.valid  = 1'b0;
        req_if.opcode = 2'($urandom);
        req_if.value  = $urandom;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on response %0d, %s: expected %h, got %h",
                         rsp_seen, field, want, got);
        end
    endtask

    initial
    begin : rsp_side
        int mode;
        int mode_left;
        int tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        hold_done = 1'b0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_req && !hold_done)
            begin
                rsp_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
                continue;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
                0: rsp_if.ready = 1'b1;
                1: rsp_if.ready = ($urandom_range(0, 3) != 0);
                2: rsp_if.ready = (tick % 3 == 0);
                default: rsp_if.ready = ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : rsp_check
        ss_pkg::ss_res_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            rsp_seen++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response %0d arrived with nothing expected", rsp_seen);
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("hit", 32'(want.hit), 32'(rsp_if.hit));
                check_field("top_value", want.top_value, rsp_if.top_value);
                check_field("fill_level", 32'(want.fill_level), 32'(rsp_if.fill_level));
                check_field("status", 32'(want.status), 32'(rsp_if.status));
            end
        end
    end

    always @(posedge clk)
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;

    initial
    begin : watchdog
        wait (quiet >= QUIET_LIMIT);
        $display("no word moved for %0d cycles, %0d responses outstanding",
                 QUIET_LIMIT, pending_rsp.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin : word_source
        int burst_left;
        int lean;
        int lean_left;
        logic [1:0]  op;
        logic [31:0] v;
        burst_left = 0;
        lean = 2;
        lean_left = 0;
        held = 0;
        hold_req = 1'b0;
        req_if.valid  = 1'b0;
        req_if.opcode = ss_pkg::OP_PUSH;
        req_if.value  = 32'h0;
        @(posedge rst_n);
        foreach (dir_rows[r])
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_word(dir_rows[r].op, dir_rows[r].val + 32'(k),
                          dir_rows[r].typed, dir_rows[r].res);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (lean_left == 0)
            begin
                lean = $urandom_range(0, 2);
                lean_left = $urandom_range(10, 40);
            end
            lean_left--;
            if (n == 200)
                hold_req = 1'b1;
            if (n == 450)
            begin
                rest(1);
                while (pending_rsp.size() != 0)
                    @(posedge clk);
            end
            op = pick_op(lean);
            v  = pick_value(op);
            send_word(op, v, 1'b0, '0);
            if (burst_left == 0)
            begin
                if (!(hold_req && !hold_done))
                    rest($urandom_range(1, 12));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                         : $urandom_range(1, 30);
            end
            else
                burst_left--;
        end
        rest(1);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        mismatches += pending_rsp.size();
        $display("covered %0d pushes (%0d refused full), %0d pops (%0d refused empty), %0d no-ops",
                 n_push, n_full, n_pop, n_empty, n_nop);
        $display("covered %0d searches (%0d hits), peak fill %0d, %0d responses, %0d mismatches",
                 n_search, n_hit, peak_fill, rsp_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
